/* hdl/xml_entity_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the entity decoder checker.
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_DECODER_DEFINES_SVH
`define XML_ENTITY_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define XED_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define XED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/xed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_pkg
// Types, character constants and the per-beat decode function of the XML
// character entity decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

    // Input beat: one string byte and its end-of-string flag.
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_beat_t;

    // Output beat: one decoded byte and its end-of-string flag.
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_beat_t;

    // Progress of a partial entity match.
    typedef enum logic [3:0] {
        MS_IDLE  = 4'd0,
        MS_AMP   = 4'd1,
        MS_L     = 4'd2,
        MS_G     = 4'd3,
        MS_LT    = 4'd4,
        MS_GT    = 4'd5,
        MS_A     = 4'd6,
        MS_AM    = 4'd7,
        MS_AMP_P = 4'd8
    } match_state_t;

    // Bytes released per input beat, and bytes one beat can produce in total.
    localparam int unsigned MAX_BEATS  = 4;
    localparam int unsigned STEP_BEATS = 5;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_P    = 8'h70;

    // Everything one input beat produces.
    typedef struct packed {
        out_beat_t [MAX_BEATS-1:0] beat;
        logic [2:0]                count;
        match_state_t              next_state;
        logic                      pend_valid;
        out_beat_t                 pend;
    } step_result_t;

    // Number of prefix bytes held in a given match state.
    function automatic logic [2:0] held_len(input match_state_t st);
        logic [2:0] len;
        unique case (st)
            MS_AMP:                      len = 3'd1;
            MS_L, MS_G, MS_A:            len = 3'd2;
            MS_LT, MS_GT, MS_AM:         len = 3'd3;
            MS_AMP_P:                    len = 3'd4;
            default:                     len = 3'd0;
        endcase
        return len;
    endfunction

    // One byte of the prefix held in a given match state.
    function automatic logic [7:0] held_char(input match_state_t st, input logic [1:0] idx);
        logic [7:0] ch;
        ch = CH_AMP;
        if (idx == 2'd1) begin
            unique case (st)
                MS_L, MS_LT:          ch = CH_L;
                MS_G, MS_GT:          ch = CH_G;
                default:              ch = CH_A;
            endcase
        end else if (idx == 2'd2) begin
            ch = (st == MS_AM || st == MS_AMP_P) ? CH_M : CH_T;
        end else if (idx == 2'd3) begin
            ch = CH_P;
        end
        return ch;
    endfunction

    // Decode one input beat against the current match state. A byte held
    // back from the previous beat goes out first.
    function automatic step_result_t entity_step(input match_state_t st,
                                                 input logic pv,
                                                 input out_beat_t pb,
                                                 input in_beat_t b);
        step_result_t               r;
        out_beat_t [STEP_BEATS-1:0] seq;
        logic [2:0]                 n;
        logic                       ok;
        logic                       done;
        logic [7:0]                 dec;
        match_state_t               nx;
        match_state_t               st_after;
        logic [2:0]                 hl;
        r        = '0;
        seq      = '0;
        n        = 3'd0;
        ok       = 1'b0;
        done     = 1'b0;
        dec      = CH_AMP;
        nx       = MS_IDLE;
        st_after = MS_IDLE;
        hl       = 3'd0;

        // The byte held back from the previous beat leads.
        if (pv) begin
            seq[0] = pb;
            n      = 3'd1;
        end

        // Advance the partial match.
        unique case (st)
            MS_AMP: begin
                if (b.in_char == CH_L) begin
                    ok = 1'b1; nx = MS_L;
                end else if (b.in_char == CH_G) begin
                    ok = 1'b1; nx = MS_G;
                end else if (b.in_char == CH_A) begin
                    ok = 1'b1; nx = MS_A;
                end
            end
            MS_L:     if (b.in_char == CH_T) begin ok = 1'b1; nx = MS_LT; end
            MS_G:     if (b.in_char == CH_T) begin ok = 1'b1; nx = MS_GT; end
            MS_A:     if (b.in_char == CH_M) begin ok = 1'b1; nx = MS_AM; end
            MS_AM:    if (b.in_char == CH_P) begin ok = 1'b1; nx = MS_AMP_P; end
            MS_LT:    if (b.in_char == CH_SEMI) begin ok = 1'b1; done = 1'b1; dec = CH_LT; end
            MS_GT:    if (b.in_char == CH_SEMI) begin ok = 1'b1; done = 1'b1; dec = CH_GT; end
            MS_AMP_P: if (b.in_char == CH_SEMI) begin ok = 1'b1; done = 1'b1; dec = CH_AMP; end
            default: begin
            end
        endcase

        // Emit the decoded character, or flush the held prefix on a mismatch.
        if (ok) begin
            if (done) begin
                seq[n].out_char = dec;
                n               = n + 3'd1;
            end
            st_after = nx;
        end else begin
            hl = held_len(st);
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < hl) begin
                    seq[n].out_char = held_char(st, 2'(i));
                    n               = n + 3'd1;
                end
            end
            if (b.in_char == CH_AMP) begin
                st_after = MS_AMP;
            end else begin
                seq[n].out_char = b.in_char;
                n               = n + 3'd1;
                st_after        = MS_IDLE;
            end
        end

        // At the end of the string, flush what is still held and mark the end.
        if (b.in_last) begin
            if (!done) begin
                hl = held_len(st_after);
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < hl) begin
                        seq[n].out_char = held_char(st_after, 2'(i));
                        n               = n + 3'd1;
                    end
                end
            end
            st_after = MS_IDLE;
            if (n != 3'd0) begin
                seq[n - 3'd1].out_last = 1'b1;
            end
        end

        // Up to four bytes leave with this beat; a fifth waits for the next one.
        for (int i = 0; i < MAX_BEATS; i++) begin
            r.beat[i] = seq[i];
        end
        if (n > 3'(MAX_BEATS)) begin
            r.count      = 3'(MAX_BEATS);
            r.pend_valid = 1'b1;
            r.pend       = seq[MAX_BEATS];
        end else begin
            r.count = n;
        end
        r.next_state = st_after;
        return r;
    endfunction

endpackage

/* hdl/xml_entity_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Streaming decoder that replaces &lt;, &gt; and &amp; in a byte string.
// ----------------------------------------------------------------------------
// Takes one string byte per beat and delivers decoded bytes one per beat. An
// accepted beat is decoded in the same cycle into zero to four output bytes,
// which are written into a five-entry output queue behind any byte left
// there; the queue head is offered on the result channel. The input is ready
// whenever at most one byte is left in that queue, so a stream in which each
// beat yields at most one byte runs at one beat per clock in both directions
// while every result beat is taken. A beat that yields more than one byte (a
// flushed partial entity) holds off the input while the queue drains. When a
// held "&amp" prefix is flushed together with a further byte, five bytes are
// due: four leave at once and the fifth is kept back and goes out first with
// the next input beat. Between beats only the match progress and that one
// kept-back byte are stored; an '&' that does not start a complete entity
// passes through unchanged, and the end-of-string flag flushes any held prefix.
// ----------------------------------------------------------------------------
module xml_entity_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  xed_pkg::in_beat_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output xed_pkg::out_beat_t m_data
);

    localparam int unsigned QDEPTH = xed_pkg::MAX_BEATS + 1;

    xed_pkg::match_state_t state_reg, state_next;
    logic                  pend_valid_reg, pend_valid_next;
    xed_pkg::out_beat_t    pend_reg, pend_next;
    xed_pkg::out_beat_t    queue_reg  [QDEPTH];
    xed_pkg::out_beat_t    queue_next [QDEPTH];
    logic [2:0]            cnt_reg, cnt_next;
    xed_pkg::step_result_t step;
    xed_pkg::out_beat_t    shifted [QDEPTH];
    xed_pkg::out_beat_t    ins     [QDEPTH];
    logic                  push;
    logic                  pop;
    logic [2:0]            keep;

    // Handshake: the queue head is the result beat.
    assign m_valid = (cnt_reg != 3'd0);
    assign m_data  = queue_reg[0];
    assign s_ready = (cnt_reg <= 3'd1);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign keep    = cnt_reg - {2'b00, pop};

    // Decode the incoming beat against the current match progress.
    assign step = xed_pkg::entity_step(state_reg, pend_valid_reg, pend_reg, s_data);

    // Shift out the delivered byte and line up the new bytes behind the kept one.
    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            shifted[i] = pop ? queue_reg[i + 1] : queue_reg[i];
        end
        shifted[QDEPTH - 1] = queue_reg[QDEPTH - 1];

        for (int i = 0; i < QDEPTH; i++) begin
            ins[i] = shifted[i];
        end
        if (keep == 3'd0) begin
            for (int i = 0; i < xed_pkg::MAX_BEATS; i++) begin
                ins[i] = step.beat[i];
            end
        end else begin
            for (int i = 1; i < QDEPTH; i++) begin
                ins[i] = step.beat[i - 1];
            end
        end

        for (int i = 0; i < QDEPTH; i++) begin
            queue_next[i] = (push && (3'(i) >= keep)) ? ins[i] : shifted[i];
        end
        cnt_next        = keep + (push ? step.count : 3'd0);
        state_next      = push ? step.next_state : state_reg;
        pend_valid_next = push ? step.pend_valid : pend_valid_reg;
        pend_next       = push ? step.pend : pend_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= 3'd0;
            state_reg      <= xed_pkg::MS_IDLE;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end else begin
            cnt_reg        <= cnt_next;
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

    // Output queue payload.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            queue_reg[i] <= queue_next[i];
        end
    end

endmodule

/* hdl/xed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_checker
// Port-level assertions for the XML entity decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "xml_entity_decoder_defines.svh"

module xed_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input xed_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input xed_pkg::out_beat_t m_data
);

    // A stalled result beat stays offered and unchanged.
    `XED_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // With nothing left to deliver, the decoder must take input.
    `XED_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input stalled with an empty output queue")

    // The end of a string always produces at least one byte.
    `XED_ASSERT_NEXT(a_last_emits, aclk, aresetn, s_valid && s_ready && s_data.in_last, m_valid, "final input beat produced no output")

    // Once the string's final byte is taken alone, input is ready or output is offered.
    `XED_ASSERT_NEXT(a_drain_ready, aclk, aresetn, m_valid && m_ready && m_data.out_last && !(s_valid && s_ready), s_ready || m_valid, "decoder wedged after end of string")

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (.*);

/* test/tb_xml_entity_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_entity_decoder
// Self-checking bench for the streaming XML character entity decoder.
// ----------------------------------------------------------------------------
// Strings of bytes are fed one beat at a time over the valid/ready input
// channel. A scoreboard tracks its own entity match progress and predicts
// every decoded output beat, which is compared in order against the result
// channel. A short directed sequence covers each entity, the five-byte flush,
// a held '&' hit by another '&' and end-of-string flushes. Random strings
// built from whole entities, broken prefixes and arbitrary bytes follow,
// under three idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_xml_entity_decoder;

    // Predicts decoded output beats and checks them as they arrive.
    class entity_scoreboard;
        xed_pkg::match_state_t progress;
        logic                  pend_valid;
        xed_pkg::out_beat_t    pend;
        xed_pkg::out_beat_t    expected_q[$];
        logic [7:0]            step_bytes[$];
        int unsigned           errors;
        int unsigned           beats_in;
        int unsigned           beats_out;
        int unsigned           strings;
        int unsigned           entities;
        int unsigned           five_byte_flushes;

        function new();
            progress          = xed_pkg::MS_IDLE;
            pend_valid        = 1'b0;
            pend              = '0;
            errors            = 0;
            beats_in          = 0;
            beats_out         = 0;
            strings           = 0;
            entities          = 0;
            five_byte_flushes = 0;
        endfunction

        // Append the prefix bytes held in a given match state.
        function void add_prefix(xed_pkg::match_state_t st);
            if (st != xed_pkg::MS_IDLE) begin
                step_bytes.push_back(xed_pkg::CH_AMP);
            end
            case (st)
                xed_pkg::MS_L, xed_pkg::MS_LT:
                    step_bytes.push_back(xed_pkg::CH_L);
                xed_pkg::MS_G, xed_pkg::MS_GT:
                    step_bytes.push_back(xed_pkg::CH_G);
                xed_pkg::MS_A, xed_pkg::MS_AM, xed_pkg::MS_AMP_P:
                    step_bytes.push_back(xed_pkg::CH_A);
                default: begin
                end
            endcase
            case (st)
                xed_pkg::MS_LT, xed_pkg::MS_GT:
                    step_bytes.push_back(xed_pkg::CH_T);
                xed_pkg::MS_AM, xed_pkg::MS_AMP_P:
                    step_bytes.push_back(xed_pkg::CH_M);
                default: begin
                end
            endcase
            if (st == xed_pkg::MS_AMP_P) begin
                step_bytes.push_back(xed_pkg::CH_P);
            end
        endfunction

        // Work out the output beats caused by one accepted input beat.
        function void note_input(xed_pkg::in_beat_t b);
            xed_pkg::match_state_t st;
            xed_pkg::match_state_t nx;
            logic                  hit;
            logic                  done;
            logic [7:0]            dec;
            xed_pkg::out_beat_t    e;
            xed_pkg::out_beat_t    step_q[$];
            st   = progress;
            nx   = xed_pkg::MS_IDLE;
            hit  = 1'b0;
            done = 1'b0;
            dec  = xed_pkg::CH_AMP;
            step_bytes.delete();
            beats_in++;

            // A byte held back from the previous beat goes out first.
            if (pend_valid) begin
                step_q.push_back(pend);
                pend_valid = 1'b0;
            end

            // Try to extend the partial match.
            case (st)
                xed_pkg::MS_AMP: begin
                    if (b.in_char == xed_pkg::CH_L) begin
                        hit = 1'b1; nx = xed_pkg::MS_L;
                    end else if (b.in_char == xed_pkg::CH_G) begin
                        hit = 1'b1; nx = xed_pkg::MS_G;
                    end else if (b.in_char == xed_pkg::CH_A) begin
                        hit = 1'b1; nx = xed_pkg::MS_A;
                    end
                end
                xed_pkg::MS_L: if (b.in_char == xed_pkg::CH_T) begin
                    hit = 1'b1; nx = xed_pkg::MS_LT;
                end
                xed_pkg::MS_G: if (b.in_char == xed_pkg::CH_T) begin
                    hit = 1'b1; nx = xed_pkg::MS_GT;
                end
                xed_pkg::MS_A: if (b.in_char == xed_pkg::CH_M) begin
                    hit = 1'b1; nx = xed_pkg::MS_AM;
                end
                xed_pkg::MS_AM: if (b.in_char == xed_pkg::CH_P) begin
                    hit = 1'b1; nx = xed_pkg::MS_AMP_P;
                end
                xed_pkg::MS_LT: if (b.in_char == xed_pkg::CH_SEMI) begin
                    hit = 1'b1; done = 1'b1; dec = xed_pkg::CH_LT;
                end
                xed_pkg::MS_GT: if (b.in_char == xed_pkg::CH_SEMI) begin
                    hit = 1'b1; done = 1'b1; dec = xed_pkg::CH_GT;
                end
                xed_pkg::MS_AMP_P: if (b.in_char == xed_pkg::CH_SEMI) begin
                    hit = 1'b1; done = 1'b1; dec = xed_pkg::CH_AMP;
                end
                default: begin
                end
            endcase

            // A full match yields the decoded character; a mismatch flushes the
            // held prefix and the byte itself, unless the byte opens a new match.
            if (hit) begin
                if (done) begin
                    step_bytes.push_back(dec);
                    entities++;
                    st = xed_pkg::MS_IDLE;
                end else begin
                    st = nx;
                end
            end else begin
                add_prefix(st);
                if (b.in_char == xed_pkg::CH_AMP) begin
                    st = xed_pkg::MS_AMP;
                end else begin
                    step_bytes.push_back(b.in_char);
                    st = xed_pkg::MS_IDLE;
                end
            end

            // The end of the string flushes whatever is still held.
            if (b.in_last) begin
                add_prefix(st);
                st = xed_pkg::MS_IDLE;
                strings++;
            end
            progress = st;

            for (int i = 0; i < step_bytes.size(); i++) begin
                e.out_char = step_bytes[i];
                e.out_last = 1'b0;
                step_q.push_back(e);
            end
            if (b.in_last && step_q.size() != 0) begin
                step_q[step_q.size() - 1].out_last = 1'b1;
            end

            // Only four bytes leave per beat; a fifth waits for the next beat.
            if (step_q.size() > xed_pkg::MAX_BEATS) begin
                five_byte_flushes++;
                pend       = step_q[xed_pkg::MAX_BEATS];
                pend_valid = 1'b1;
                void'(step_q.pop_back());
            end
            for (int i = 0; i < step_q.size(); i++) begin
                expected_q.push_back(step_q[i]);
            end
        endfunction

        // Compare one accepted output beat with the oldest prediction.
        function void check_result(xed_pkg::out_beat_t got);
            xed_pkg::out_beat_t e;
            beats_out++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output beat, char %02h last %0b",
                         $time, got.out_char, got.out_last);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (got.out_char !== e.out_char) begin
                    $display("%0t: out_char mismatch, expected %02h actual %02h",
                             $time, e.out_char, got.out_char);
                    errors++;
                end
                if (got.out_last !== e.out_last) begin
                    $display("%0t: out_last mismatch, expected %0b actual %0b",
                             $time, e.out_last, got.out_last);
                    errors++;
                end
            end
        endfunction
    endclass

    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_BEATS     = 140;
    localparam int unsigned DRAIN_LIMIT     = 50000;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    xed_pkg::in_beat_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    xed_pkg::out_beat_t m_data;

    entity_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_requests = 0;
    logic [7:0]  str_q[$];

    xml_entity_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one input beat, with random idle cycles ahead of it.
    task automatic send_beat(input logic [7:0] ch, input logic last);
        xed_pkg::in_beat_t b;
        b.in_char = ch;
        b.in_last = last;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(b);
    endtask

    // Send the bytes collected in str_q as one string, flagging the final byte.
    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++) begin
            send_beat(str_q[i], i == str_q.size() - 1);
        end
        str_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            str_q.push_back(s[i]);
        end
    endtask

    // Build a random string of entities, broken prefixes, '&' and other bytes.
    task automatic build_random_string();
        string       ent;
        string       letters;
        int unsigned ntok;
        int unsigned k;
        letters = "lgtamp;&";
        ntok = $urandom_range(1, 10);
        for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(2))
                0:       ent = "&lt;";
                1:       ent = "&gt;";
                default: ent = "&amp;";
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: push_text(ent);
                4: begin
                    k = $urandom_range(1, ent.len() - 1);
                    for (int i = 0; i < k; i++) begin
                        str_q.push_back(ent[i]);
                    end
                end
                5:       str_q.push_back(xed_pkg::CH_AMP);
                6, 7, 8: str_q.push_back(8'($urandom_range(1, 255)));
                default: str_q.push_back(letters[$urandom_range(7)]);
            endcase
        end
    endtask

    task automatic run_random_phase(input int unsigned snd_pct,
                                    input int unsigned rcv_pct);
        int unsigned start_beats;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start_beats   = sb.beats_in;
        while (sb.beats_in - start_beats < PHASE_BEATS) begin
            build_random_string();
            send_string();
        end
    endtask

    // Result channel: check accepted beats and drive ready with random stalls.
    initial begin
        int unsigned hold_left;
        int unsigned requests_seen;
        hold_left     = 0;
        requests_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if (requests_seen != hold_off_requests) begin
                requests_seen = hold_off_requests;
                hold_left     = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed strings: every entity, the five-byte flush with the top
        // byte value, a held '&' followed by another '&', a string ending in
        // the middle of an entity, and a one-byte string with the byte 01h.
        send_idle_pct = 8;
        recv_idle_pct = 59;
        push_text("&lt;&gt;&amp;");
        send_string();
        push_text("&amp");
        str_q.push_back(8'hFF);
        send_string();
        push_text("&&amp");
        send_string();
        push_text("&amp&");
        send_string();
        str_q.push_back(8'h01);
        send_string();

        run_random_phase(8, 59);
        run_random_phase(59, 8);

        // Hold the receiver off while beats keep coming, so the input stalls.
        hold_off_requests = hold_off_requests + 1;
        run_random_phase(0, 0);

        s_valid <= 1'b0;
        waited = 0;
        while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);

        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d predicted output beats never arrived",
                     $time, sb.expected_q.size());
        end
        $display("Covered %0d strings, %0d input beats, %0d output beats checked.",
                 sb.strings, sb.beats_in, sb.beats_out);
        $display("Decoded %0d entities, saw %0d five-byte flushes, one long hold-off.",
                 sb.entities, sb.five_byte_flushes);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("%0t: watchdog expired", $time);
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/xed_pkg.sv
hdl/xml_entity_decoder.sv
hdl/xed_checker.sv
test/tb_xml_entity_decoder.sv
